// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/dcf_pkg.sv =====
`default_nettype none
package dcf_pkg;
  localparam int MaxVertices = 32;
  localparam int MaxEdges    = 256;
  localparam int VW   = $clog2(MaxVertices);
  localparam int EW   = $clog2(MaxEdges);
  localparam int CntW = VW + 1;
  localparam int TotW = EW + 1;
  localparam int FW   = 6;

  typedef enum logic [1:0] {
    ColWhite = 2'd0,
    ColGrey  = 2'd1,
    ColBlack = 2'd2
  } color_e;

  typedef struct packed {
    logic load;
    logic scan_next;
    logic push_start;
    logic pop;
    logic fetch;
    logic eval;
    logic out_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic scan_white;
    logic stack_empty;
    logic top_has_edge;
    logic hit_grey;
    logic out_last;
  } sts_t;
endpackage
`default_nettype wire

// ===== sv/dcf_edge_if.sv =====
`default_nettype none
interface dcf_edge_if;
  import dcf_pkg::*;
  logic          valid;
  logic          ready;
  logic          has_edge;
  logic [FW-1:0] src_vertex;
  logic [FW-1:0] dst_vertex;
  logic          last_edge;
  modport source (output valid, has_edge, src_vertex, dst_vertex, last_edge, input ready);
  modport sink (input valid, has_edge, src_vertex, dst_vertex, last_edge, output ready);
endinterface
`default_nettype wire

// ===== sv/dcf_result_if.sv =====
`default_nettype none
interface dcf_result_if;
  import dcf_pkg::*;
  logic          valid;
  logic          ready;
  logic          cycle_found;
  logic [FW-1:0] cycle_vertex;
  logic          dropped_edges;
  logic          last;
  modport source (output valid, cycle_found, cycle_vertex, dropped_edges, last, input ready);
  modport sink (input valid, cycle_found, cycle_vertex, dropped_edges, last, output ready);
endinterface
`default_nettype wire

// ===== sv/dcf_ctrl.sv =====
`default_nettype none
module dcf_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  wire logic         in_last_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  input  wire dcf_pkg::sts_t sts_i,
  output dcf_pkg::cmd_t     cmd_o
);
  import dcf_pkg::*;

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StTop  = 3'd2;
  localparam logic [2:0] StEval = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam logic [2:0] StNone = 3'd5;

  logic [2:0] state_q, state_d;

  // Sequence loading, search steps and result delivery
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) state_d = StScan;
        end
      end
      StScan: begin
        if (sts_i.scan_done) begin
          state_d = StNone;
        end else if (!sts_i.scan_white) begin
          cmd_o.scan_next = 1'b1;
        end else begin
          cmd_o.push_start = 1'b1;
          state_d = StTop;
        end
      end
      StTop: begin
        if (sts_i.stack_empty) begin
          cmd_o.scan_next = 1'b1;
          state_d = StScan;
        end else if (!sts_i.top_has_edge) begin
          cmd_o.pop = 1'b1;
        end else begin
          cmd_o.fetch = 1'b1;
          state_d = StEval;
        end
      end
      StEval: begin
        cmd_o.eval = 1'b1;
        state_d = sts_i.hit_grey ? StOut : StTop;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (sts_i.out_last) begin
            cmd_o.clear = 1'b1;
            state_d = StLoad;
          end else begin
            cmd_o.out_next = 1'b1;
          end
        end
      end
      StNone: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.clear = 1'b1;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StLoad;
    else state_q <= state_d;
  end
endmodule
`default_nettype wire

// ===== sv/dcf_datapath.sv =====
`default_nettype none
module dcf_datapath (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [dcf_pkg::FW-1:0] cfg_data_i,
  input  wire logic                  has_edge_i,
  input  wire logic [dcf_pkg::FW-1:0] src_vertex_i,
  input  wire logic [dcf_pkg::FW-1:0] dst_vertex_i,
  input  wire dcf_pkg::cmd_t         cmd_i,
  output dcf_pkg::sts_t              sts_o,
  output logic                       cycle_found_o,
  output logic [dcf_pkg::FW-1:0]     cycle_vertex_o,
  output logic                       dropped_edges_o,
  output logic                       last_o
);
  import dcf_pkg::*;

  logic [FW-1:0]   vcount_q;
  logic [FW-1:0]   n_eff;
  logic [TotW-1:0] total_q;
  logic            drop_q;
  logic            found_q;
  logic [CntW-1:0] s_q;
  logic [CntW-1:0] sp_q;
  logic [VW-1:0]   out_idx_q;

  logic [EW-1:0]   head_q   [MaxVertices];
  logic [EW-1:0]   tail_q   [MaxVertices];
  logic            lvalid_q [MaxVertices];
  color_e          color_q  [MaxVertices];
  logic [VW-1:0]   depth_q  [MaxVertices];
  logic [VW-1:0]   pvert_q  [MaxVertices];
  logic [EW-1:0]   pcur_q   [MaxVertices];
  logic            pcval_q  [MaxVertices];

  logic [VW-1:0]   tgt_mem  [MaxEdges];
  logic [EW-1:0]   link_mem [MaxEdges];
  logic [VW-1:0]   tgt_rd_q;
  logic [EW-1:0]   link_rd_q;

  logic [FW-1:0]   src_m1, dst_m1;
  logic [VW-1:0]   sv, dv, top, v_top, t, push_v, s_idx;
  logic [EW-1:0]   e_new;
  logic            edge_ok, do_push, hit_white;

  // Clamp the vertex count into its legal range
  always_comb begin
    if (vcount_q == '0) n_eff = FW'(1);
    else if (vcount_q > FW'(MaxVertices)) n_eff = FW'(MaxVertices);
    else n_eff = vcount_q;
  end

  assign src_m1  = src_vertex_i - FW'(1);
  assign dst_m1  = dst_vertex_i - FW'(1);
  assign sv      = src_m1[VW-1:0];
  assign dv      = dst_m1[VW-1:0];
  assign e_new   = total_q[EW-1:0];
  assign edge_ok = (src_vertex_i != '0) && (src_vertex_i <= n_eff) &&
                   (dst_vertex_i != '0) && (dst_vertex_i <= n_eff) &&
                   (total_q < TotW'(MaxEdges));

  assign top       = VW'(sp_q - CntW'(1));
  assign v_top     = pvert_q[top];
  assign t         = tgt_rd_q;
  assign s_idx     = s_q[VW-1:0];
  assign hit_white = (color_q[t] == ColWhite);
  assign do_push   = cmd_i.push_start || (cmd_i.eval && hit_white);
  assign push_v    = cmd_i.push_start ? s_idx : t;

  assign sts_o.scan_done    = (s_q >= CntW'(n_eff));
  assign sts_o.scan_white   = (color_q[s_idx] == ColWhite);
  assign sts_o.stack_empty  = (sp_q == '0);
  assign sts_o.top_has_edge = pcval_q[top];
  assign sts_o.hit_grey     = (color_q[t] == ColGrey);
  assign sts_o.out_last     = (out_idx_q == top);

  // Drive the result payload
  assign cycle_found_o   = found_q;
  assign cycle_vertex_o  = found_q ? (FW'(pvert_q[out_idx_q]) + FW'(1)) : '0;
  assign dropped_edges_o = drop_q;
  assign last_o          = found_q ? sts_o.out_last : 1'b1;

  // Edge store: append on load, read at the top cursor on fetch
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_edge_i && edge_ok) begin
      tgt_mem[e_new] <= dv;
      if (lvalid_q[sv]) link_mem[tail_q[sv]] <= e_new;
    end
    if (cmd_i.fetch) begin
      tgt_rd_q  <= tgt_mem[pcur_q[top]];
      link_rd_q <= link_mem[pcur_q[top]];
    end
  end

  // Search scratch that needs no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && has_edge_i && edge_ok) begin
      tail_q[sv] <= e_new;
      if (!lvalid_q[sv]) head_q[sv] <= e_new;
    end
    if (cmd_i.eval) pcur_q[top] <= link_rd_q;
    if (cmd_i.fetch) pcval_q[top] <= (pcur_q[top] != tail_q[v_top]);
    if (do_push && (sp_q < CntW'(MaxVertices))) begin
      pvert_q[sp_q[VW-1:0]] <= push_v;
      pcur_q[sp_q[VW-1:0]]  <= head_q[push_v];
      pcval_q[sp_q[VW-1:0]] <= lvalid_q[push_v];
      depth_q[push_v]       <= sp_q[VW-1:0];
    end
  end

  // Control state, colors and list valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= FW'(MaxVertices);
      total_q   <= '0;
      drop_q    <= 1'b0;
      found_q   <= 1'b0;
      s_q       <= '0;
      sp_q      <= '0;
      out_idx_q <= '0;
      for (int i = 0; i < MaxVertices; i++) begin
        lvalid_q[i] <= 1'b0;
        color_q[i]  <= ColWhite;
      end
    end else begin
      if (cfg_we_i) vcount_q <= cfg_data_i;
      if (cmd_i.load && has_edge_i) begin
        if (edge_ok) begin
          lvalid_q[sv] <= 1'b1;
          total_q      <= total_q + TotW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.scan_next) s_q <= s_q + CntW'(1);
      if (cmd_i.pop) begin
        color_q[v_top] <= ColBlack;
        sp_q           <= sp_q - CntW'(1);
      end
      if (do_push && (sp_q < CntW'(MaxVertices))) begin
        color_q[push_v] <= ColGrey;
        sp_q            <= sp_q + CntW'(1);
      end
      if (cmd_i.eval && sts_o.hit_grey) begin
        found_q   <= 1'b1;
        out_idx_q <= depth_q[t];
      end
      if (cmd_i.out_next) out_idx_q <= out_idx_q + VW'(1);
      if (cmd_i.clear) begin
        total_q <= '0;
        drop_q  <= 1'b0;
        found_q <= 1'b0;
        s_q     <= '0;
        sp_q    <= '0;
        for (int i = 0; i < MaxVertices; i++) begin
          lvalid_q[i] <= 1'b0;
          color_q[i]  <= ColWhite;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/directed_cycle_finder_core.sv =====
`default_nettype none
// Directed cycle finder. Edges stream in one per cycle and are appended to
// per-vertex out-lists in a 256-entry edge store. The transaction with
// last_edge set starts a colored depth-first search over vertices 1..vertex_count
// (0 acts as 1, above 32 as 32); no input is taken until the answer is out.
// The search examines each start vertex in turn; one that is white opens a new
// tree, which ends when its stack is found empty again. A vertex with no edge
// left is popped; each edge followed takes a fetch step, the registered read of
// the edge store, and then an evaluation step. The answer is either one
// transaction with cycle_found = 0 or the cycle vertices from the revisited
// vertex to the one closing the cycle, one per cycle while the receiver is
// ready, last marked. Self-loops are cycles. Edges with bad endpoints or past
// capacity are dropped and reported through dropped_edges. After the last result
// all graph state is cleared; vertex_count is kept.
module directed_cycle_finder_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [dcf_pkg::FW-1:0] cfg_data_i,
  dcf_edge_if.sink                    edge_i,
  dcf_result_if.source                result_o
);
  import dcf_pkg::*;
`include "assert_macros.svh"

  cmd_t cmd;
  sts_t sts;

  dcf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (edge_i.valid),
    .in_last_i   (edge_i.last_edge),
    .in_ready_o  (edge_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dcf_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .has_edge_i      (edge_i.has_edge),
    .src_vertex_i    (edge_i.src_vertex),
    .dst_vertex_i    (edge_i.dst_vertex),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cycle_found_o   (result_o.cycle_found),
    .cycle_vertex_o  (result_o.cycle_vertex),
    .dropped_edges_o (result_o.dropped_edges),
    .last_o          (result_o.last)
  );

  // Loading and answering never overlap
  `ASSERT_IMPL(a_no_overlap, clk_i, rst_ni, result_o.valid, !edge_i.ready)
  // A no-cycle answer carries vertex zero and ends the graph
  `ASSERT_IMPL(a_none_form, clk_i, rst_ni, result_o.valid && !result_o.cycle_found,
               result_o.cycle_vertex == '0 && result_o.last)
  // The final result returns the block to loading
  `ASSERT_NEXT(a_back_to_load, clk_i, rst_ni,
               result_o.valid && result_o.ready && result_o.last, edge_i.ready)
endmodule
`default_nettype wire

// ===== sim/directed_cycle_finder_core_test.sv =====
`default_nettype none
module directed_cycle_finder_core_test;
  import dcf_pkg::*;

  typedef struct packed {
    logic       found;
    logic [5:0] vert;
    logic       drop;
    logic       last;
  } answer_t;

  typedef struct {
    bit         has_edge;
    bit [5:0]   src;
    bit [5:0]   dst;
    bit         last_edge;
    bit         typed;
    answer_t    answer;
  } row_t;

  localparam int NumV       = 32;
  localparam int NumE       = 256;
  localparam int WatchLimit = 6000;
  localparam int SettleWait = 600;
  localparam int HoldCycles = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [FW-1:0] cfg_data;

  dcf_edge_if   ein();
  dcf_result_if rout();

  directed_cycle_finder_core dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .edge_i    (ein),
    .result_o  (rout)
  );

  // Predictor state: graph store, search scratch and the count register
  logic [5:0] vcount;
  int         head [NumV];
  int         tail [NumV];
  bit         head_ok [NumV];
  int         target [NumE];
  int         link [NumE];
  bit         link_ok [NumE];
  int         stored;
  color_e     color [NumV];
  int         parent [NumV];
  int         stack_v [NumV];
  int         stack_c [NumV];
  bit         stack_ok [NumV];
  bit         dropped;

  answer_t answer_q[$];

  int src_idle, snk_idle;
  int items_sent, graphs_done, cycles_seen, results_seen;
  int mismatches;
  bit hold_req;

  // Append one expected result at the tail of the queue
  function automatic void queue_answer(answer_t a);
    answer_q = {answer_q, a};
  endfunction

  function automatic void clear_graph();
    for (int i = 0; i < NumV; i++) begin
      head[i] = 0; tail[i] = 0; head_ok[i] = 0; color[i] = ColWhite;
      parent[i] = 0; stack_v[i] = 0; stack_c[i] = 0; stack_ok[i] = 0;
    end
    for (int i = 0; i < NumE; i++) begin
      target[i] = 0; link[i] = 0; link_ok[i] = 0;
    end
    stored = 0;
    dropped = 0;
  endfunction

  function automatic int active_count();
    if (vcount == 0) return 1;
    if (vcount > NumV) return NumV;
    return vcount;
  endfunction

  function automatic void push_vertex(inout int sp, input int v);
    if (sp >= NumV) return;
    color[v] = ColGrey;
    stack_v[sp] = v;
    stack_c[sp] = head[v];
    stack_ok[sp] = head_ok[v];
    sp++;
  endfunction

  // Colored DFS; stop at the first edge into a grey vertex
  function automatic bit find_cycle(output int first, output int closer);
    int n, sp, top, v, e, t;
    n = active_count();
    first = 0;
    closer = 0;
    for (int s = 0; s < n; s++) begin
      if (color[s] != ColWhite) continue;
      sp = 0;
      push_vertex(sp, s);
      while (sp > 0) begin
        top = sp - 1;
        v = stack_v[top];
        if (!stack_ok[top]) begin
          color[v] = ColBlack;
          sp--;
          continue;
        end
        e = stack_c[top] % NumE;
        stack_ok[top] = link_ok[e];
        stack_c[top] = link[e];
        t = target[e] % NumV;
        if (color[t] == ColGrey) begin
          first = t;
          closer = v;
          return 1;
        end
        if (color[t] == ColWhite) begin
          parent[t] = v;
          push_vertex(sp, t);
        end
      end
    end
    return 0;
  endfunction

  // Append the edge, and on the closing transaction queue the answer
  function automatic int predict_answer(bit he, bit [5:0] s, bit [5:0] d, bit le);
    int n, e, sv, first, closer, v, len, tl;
    int chain [NumV];
    answer_t a;
    if (he) begin
      n = active_count();
      if (s == 0 || s > n || d == 0 || d > n || stored >= NumE) begin
        dropped = 1;
      end else begin
        e = stored;
        sv = s - 1;
        target[e] = d - 1;
        link[e] = 0;
        link_ok[e] = 0;
        if (head_ok[sv]) begin
          tl = tail[sv] % NumE;
          link[tl] = e;
          link_ok[tl] = 1;
        end else begin
          head[sv] = e;
          head_ok[sv] = 1;
        end
        tail[sv] = e;
        stored++;
      end
    end
    if (!le) return 0;
    graphs_done++;
    if (!find_cycle(first, closer)) begin
      a = '{found: 1'b0, vert: 6'd0, drop: dropped, last: 1'b1};
      queue_answer(a);
      clear_graph();
      return 1;
    end
    cycles_seen++;
    len = 0;
    v = closer;
    while (len < NumV) begin
      chain[len++] = v;
      if (v == first) break;
      v = parent[v % NumV] % NumV;
    end
    for (int k = 0; k < len; k++) begin
      a.found = 1'b1;
      a.vert = 6'((chain[len - 1 - k] + 1) & 6'h3f);
      a.drop = dropped;
      a.last = (k + 1 == len);
      queue_answer(a);
    end
    clear_graph();
    return len;
  endfunction

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Receiver: check each result transaction, then pick next ready
  int hold_left;
  initial begin
    rout.ready = 1'b0;
    hold_left = 0;
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && rout.valid && rout.ready) begin
      got = '{rout.cycle_found, rout.cycle_vertex, rout.dropped_edges, rout.last};
      results_seen++;
      if (answer_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: found=%0d vertex=%0d drop=%0d last=%0d",
                   got.found, got.vert, got.drop, got.last);
      end else begin
        want = answer_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result mismatch: expected found=%0d vertex=%0d drop=%0d last=%0d",
                     want.found, want.vert, want.drop, want.last);
            $display("                 actual   found=%0d vertex=%0d drop=%0d last=%0d",
                     got.found, got.vert, got.drop, got.last);
          end
        end
      end
    end
    if (hold_req && hold_left == 0) hold_left = HoldCycles;
    if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_req = 0;
      rout.ready <= 1'b0;
    end else begin
      rout.ready <= ($urandom_range(0, 99) >= snk_idle);
    end
  end

  // Watchdog on cycles without any transaction
  int quiet;
  always @(posedge clk) begin
    if ((ein.valid && ein.ready) || (rout.valid && rout.ready)) quiet = 0;
    else quiet++;
    if (quiet >= WatchLimit) begin
      $display("watchdog expired with %0d results outstanding", answer_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // Offer one edge transaction and predict once it is taken
  task automatic send(bit he, bit [5:0] s, bit [5:0] d, bit le,
                      bit typed = 0, answer_t want = '0);
    int pushed;
    if ($urandom_range(0, 99) < src_idle) begin
      ein.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < src_idle);
    end
    ein.valid <= 1'b1;
    ein.has_edge <= he;
    ein.src_vertex <= s;
    ein.dst_vertex <= d;
    ein.last_edge <= le;
    do @(posedge clk); while (!ein.ready);
    items_sent++;
    pushed = predict_answer(he, s, d, le);
    if (typed) begin
      repeat (pushed) void'(answer_q.pop_back());
      queue_answer(want);
    end
  endtask

  // Drain outstanding answers and let the clearing pass finish
  task automatic settle();
    ein.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_count(bit [5:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = value;
  endtask

  // Mostly well-formed edges, some noise and empty transactions
  task automatic send_graph(int edges);
    int n, r;
    bit le;
    n = active_count();
    for (int k = 0; k < edges; k++) begin
      r = $urandom_range(0, 99);
      le = (k == edges - 1);
      if (r < 10)
        send(1'b0, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), le);
      else if (r < 18)
        send(1'b1, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), le);
      else
        send(1'b1, 6'($urandom_range(1, n)), 6'($urandom_range(1, n)), le);
    end
  endtask

  task automatic random_phase(int quota);
    int stop;
    stop = items_sent + quota;
    while (items_sent < stop) begin
      if ($urandom_range(0, 5) == 0) begin
        settle();
        write_count(6'($urandom_range(1, 32)));
      end
      send_graph($urandom_range(1, 12));
    end
  endtask

  row_t rows [$];

  initial begin
    ein.valid = 1'b0;
    ein.has_edge = 1'b0;
    ein.src_vertex = '0;
    ein.dst_vertex = '0;
    ein.last_edge = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_req = 0;
    src_idle = 0;
    snk_idle = 0;
    items_sent = 0; graphs_done = 0; cycles_seen = 0; results_seen = 0;
    mismatches = 0;
    quiet = 0;
    vcount = 6'd32;
    clear_graph();

    // Directed table: extremes, drops, self-loops, short cycles
    rows = '{
      '{0, 0, 0, 1, 1, '{1'b0, 6'd0, 1'b0, 1'b1}},
      '{1, 1, 1, 1, 1, '{1'b1, 6'd1, 1'b0, 1'b1}},
      '{1, 0, 5, 1, 1, '{1'b0, 6'd0, 1'b1, 1'b1}},
      '{1, 63, 1, 1, 1, '{1'b0, 6'd0, 1'b1, 1'b1}},
      '{1, 33, 33, 1, 1, '{1'b0, 6'd0, 1'b1, 1'b1}},
      '{1, 32, 32, 1, 1, '{1'b1, 6'd32, 1'b0, 1'b1}},
      '{1, 1, 2, 0, 0, '0},
      '{1, 2, 3, 0, 0, '0},
      '{1, 3, 1, 1, 0, '0},
      '{1, 1, 2, 0, 0, '0},
      '{0, 63, 63, 0, 0, '0},
      '{0, 42, 21, 1, 0, '0},
      '{1, 3, 5, 0, 0, '0},
      '{1, 5, 0, 0, 0, '0},
      '{1, 5, 3, 1, 0, '0},
      '{1, 1, 32, 0, 0, '0},
      '{1, 32, 16, 0, 0, '0},
      '{1, 16, 8, 0, 0, '0},
      '{1, 8, 32, 0, 0, '0},
      '{1, 2, 2, 1, 0, '0}
    };

    @(posedge rst_n);
    @(posedge clk);
    foreach (rows[i])
      send(rows[i].has_edge, rows[i].src, rows[i].dst, rows[i].last_edge,
           rows[i].typed, rows[i].answer);

    // Register extremes: 0 acts as one vertex, 63 acts as the maximum
    settle();
    write_count(6'd0);
    send(1'b1, 6'd2, 6'd1, 1'b0);
    send(1'b1, 6'd1, 6'd1, 1'b1);
    settle();
    write_count(6'd63);
    send(1'b1, 6'd31, 6'd32, 1'b0);
    send(1'b1, 6'd32, 6'd31, 1'b1);
    settle();
    write_count(6'd1);
    send(1'b1, 6'd1, 6'd2, 1'b1);

    // Lower the count in the middle of loading a graph
    settle();
    write_count(6'd32);
    send(1'b1, 6'd20, 6'd21, 1'b0);
    send(1'b1, 6'd21, 6'd20, 1'b0);
    ein.valid <= 1'b0;
    repeat (20) @(posedge clk);
    write_count(6'd5);
    send(1'b1, 6'd4, 6'd20, 1'b0);
    send(1'b1, 6'd1, 6'd4, 1'b1);

    // Sender idles more lightly, receiver heavily; include a long hold-off
    settle();
    write_count(6'd32);
    src_idle = 20;
    snk_idle = 80;
    hold_req = 1;
    random_phase(70);

    // Swap; pause the sender until every answer has come
    src_idle = 80;
    snk_idle = 20;
    random_phase(35);
    ein.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    random_phase(35);

    // Full throughput
    settle();
    src_idle = 0;
    snk_idle = 0;
    write_count(6'd32);
    random_phase(60);

    ein.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("sent %0d edge transactions over %0d graphs", items_sent, graphs_done);
    $display("checked %0d results, %0d graphs with a cycle, %0d mismatches",
             results_seen, cycles_seen, mismatches);
    if (mismatches == 0 && answer_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
